// ----- rtl/deposit_kiosk_controller_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Deposit kiosk controller assertion macros
// Short forms for the clocked, reset-qualified properties used in the RTL.
// ----------------------------------------------------------------------------
`ifndef DEPOSIT_KIOSK_CONTROLLER_UNIT_MACROS_SVH
`define DEPOSIT_KIOSK_CONTROLLER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DKC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("deposit kiosk controller: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define DKC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("deposit kiosk controller: next-cycle check failed");

`endif

// ----- rtl/dkc_pkg.sv -----
// ----------------------------------------------------------------------------
// Deposit kiosk controller package
// Types, reset values and helper functions shared by the controller modules.
// ----------------------------------------------------------------------------
package dkc_pkg;

    localparam int TIMER_BITS = 16;
    localparam int LIMIT_BITS = 16;
    localparam int CMP_BITS   = (TIMER_BITS > LIMIT_BITS) ? TIMER_BITS : LIMIT_BITS;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;
    localparam int IN_DATA_BITS   = 24;
    localparam int OUT_DATA_BITS  = 24;
    localparam int OUT_USED_BITS  = 17;

    localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

    localparam logic [15:0] DETECT_TIMEOUT_RST = 16'd3000;
    localparam logic [15:0] SCAN_TIMEOUT_RST   = 16'd5000;
    localparam logic [15:0] ACCEPT_WINDOW_RST  = 16'd3000;
    localparam logic [15:0] REJECT_TIME_RST    = 16'd3000;
    localparam logic [8:0]  FULL_DISTANCE_RST  = 9'd10;
    localparam logic [9:0]  BLINK_HALF_RST     = 10'd400;
    localparam logic [7:0]  DRIVE_DUTY_RST     = 8'd200;
    localparam logic [7:0]  MIN_CODE_LEN_RST   = 8'd5;

    typedef enum logic [2:0] {
        MODE_READY    = 3'd0,
        MODE_DETECTED = 3'd1,
        MODE_SCANNING = 3'd2,
        MODE_ACCEPTED = 3'd3,
        MODE_REFUSED  = 3'd4,
        MODE_FULL     = 3'd5
    } mode_t;

    typedef enum logic [1:0] {
        MOTOR_STOP = 2'd0,
        MOTOR_FWD  = 2'd1,
        MOTOR_REV  = 2'd2
    } motor_t;

    typedef enum logic [1:0] {
        LED_GREEN = 2'd0,
        LED_BLUE  = 2'd1,
        LED_OFF   = 2'd2,
        LED_RED   = 2'd3
    } led_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_DETECT_TIMEOUT = 3'd0,
        CFG_SCAN_TIMEOUT   = 3'd1,
        CFG_ACCEPT_WINDOW  = 3'd2,
        CFG_REJECT_TIME    = 3'd3,
        CFG_FULL_DISTANCE  = 3'd4,
        CFG_BLINK_HALF     = 3'd5,
        CFG_DRIVE_DUTY     = 3'd6,
        CFG_MIN_CODE_LEN   = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic [15:0] detect_timeout_ms;
        logic [15:0] scan_timeout_ms;
        logic [15:0] accept_window_ms;
        logic [15:0] reject_time_ms;
        logic [8:0]  full_distance_cm;
        logic [9:0]  blink_half_ms;
        logic [7:0]  drive_duty;
        logic [7:0]  min_code_length;
    } cfg_t;

    typedef struct packed {
        logic       entry_edge;
        logic       code_ready;
        logic [7:0] code_length;
        logic       verdict_valid;
        logic       verdict_ok;
        logic       range_valid;
        logic [8:0] range_cm;
        logic       first_gate_low;
        logic       second_gate_low;
    } in_item_t;

    typedef struct packed {
        mode_t      mode_now;
        motor_t     motor_direction;
        logic [7:0] motor_pwm;
        led_t       led_colour;
        logic       publish_scan;
        logic       publish_confirm;
    } out_item_t;

    typedef struct packed {
        mode_t                 mode;
        logic [TIMER_BITS-1:0] elapsed_ms;
        logic [9:0]            blink_count;
        logic                  blink_phase;
        logic                  entry_pending;
        logic                  scanner_enabled;
        logic                  first_seen;
        logic                  second_seen;
        logic                  confirmed;
        motor_t                motor;
    } state_t;

    localparam state_t STATE_RST = '{
        mode:            MODE_READY,
        elapsed_ms:      '0,
        blink_count:     '0,
        blink_phase:     1'b0,
        entry_pending:   1'b0,
        scanner_enabled: 1'b1,
        first_seen:      1'b0,
        second_seen:     1'b0,
        confirmed:       1'b0,
        motor:           MOTOR_STOP
    };

    // True once the elapsed time has gone strictly past the limit.
    function automatic logic timed_out(input logic [TIMER_BITS-1:0] elapsed,
                                       input logic [LIMIT_BITS-1:0] limit);
        return CMP_BITS'(elapsed) > CMP_BITS'(limit);
    endfunction

endpackage

// ----- rtl/dkc_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// Deposit kiosk controller configuration registers
// Write-only register file; each register keeps only its own width.
// ----------------------------------------------------------------------------
module dkc_cfg_regs (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [dkc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [dkc_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    output dkc_pkg::cfg_t                       cfg
);
    import dkc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index_t'(cfg_index))
                CFG_DETECT_TIMEOUT: cfg_next.detect_timeout_ms = cfg_data;
                CFG_SCAN_TIMEOUT:   cfg_next.scan_timeout_ms   = cfg_data;
                CFG_ACCEPT_WINDOW:  cfg_next.accept_window_ms  = cfg_data;
                CFG_REJECT_TIME:    cfg_next.reject_time_ms    = cfg_data;
                CFG_FULL_DISTANCE:  cfg_next.full_distance_cm  = cfg_data[8:0];
                CFG_BLINK_HALF:     cfg_next.blink_half_ms     = cfg_data[9:0];
                CFG_DRIVE_DUTY:     cfg_next.drive_duty        = cfg_data[7:0];
                CFG_MIN_CODE_LEN:   cfg_next.min_code_length   = cfg_data[7:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.detect_timeout_ms <= DETECT_TIMEOUT_RST;
            cfg_reg.scan_timeout_ms   <= SCAN_TIMEOUT_RST;
            cfg_reg.accept_window_ms  <= ACCEPT_WINDOW_RST;
            cfg_reg.reject_time_ms    <= REJECT_TIME_RST;
            cfg_reg.full_distance_cm  <= FULL_DISTANCE_RST;
            cfg_reg.blink_half_ms     <= BLINK_HALF_RST;
            cfg_reg.drive_duty        <= DRIVE_DUTY_RST;
            cfg_reg.min_code_length   <= MIN_CODE_LEN_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/dkc_step.sv -----
// ----------------------------------------------------------------------------
// Deposit kiosk controller tick logic
// Next-state and result logic for one millisecond tick.
// ----------------------------------------------------------------------------
module dkc_step (
    input  dkc_pkg::cfg_t      cfg,
    input  dkc_pkg::state_t    state_cur,
    input  dkc_pkg::in_item_t  item,
    output dkc_pkg::state_t    state_upd,
    output dkc_pkg::out_item_t result
);
    import dkc_pkg::*;

    state_t n;
    logic   pub_scan;
    logic   pub_confirm;
    led_t   led;

    always_comb begin
        n           = state_cur;
        pub_scan    = 1'b0;
        pub_confirm = 1'b0;
        led         = LED_OFF;

        // Timer and blink counter advance first.
        if (n.elapsed_ms != TIMER_MAX) begin
            n.elapsed_ms = n.elapsed_ms + 1'b1;
        end
        if (n.blink_count >= cfg.blink_half_ms) begin
            n.blink_phase = ~n.blink_phase;
            n.blink_count = '0;
        end else begin
            n.blink_count = n.blink_count + 1'b1;
        end

        if (item.entry_edge && (n.mode == MODE_READY)) begin
            n.entry_pending = 1'b1;
        end

        // The server verdict overrides whatever mode we were in.
        if (item.verdict_valid) begin
            n.elapsed_ms = '0;
            if (item.verdict_ok) begin
                n.mode        = MODE_ACCEPTED;
                n.first_seen  = 1'b0;
                n.second_seen = 1'b0;
                n.confirmed   = 1'b0;
                n.motor       = MOTOR_FWD;
            end else begin
                n.mode  = MODE_REFUSED;
                n.motor = MOTOR_REV;
            end
        end

        // Bin level check; a zero reading means no echo.
        if (item.range_valid) begin
            if ((item.range_cm != '0) && (item.range_cm < cfg.full_distance_cm)) begin
                n.mode = MODE_FULL;
            end else if ((item.range_cm >= cfg.full_distance_cm) && (n.mode == MODE_FULL)) begin
                n.mode = MODE_READY;
            end
        end

        case (n.mode)
            MODE_READY: begin
                if (n.entry_pending) begin
                    n.entry_pending   = 1'b0;
                    n.mode            = MODE_DETECTED;
                    n.elapsed_ms      = '0;
                    n.scanner_enabled = 1'b1;
                end
            end
            MODE_DETECTED: begin
                if (timed_out(n.elapsed_ms, cfg.detect_timeout_ms)) begin
                    n.mode            = MODE_REFUSED;
                    n.elapsed_ms      = '0;
                    n.motor           = MOTOR_REV;
                    n.scanner_enabled = 1'b0;
                end else if (n.scanner_enabled && item.code_ready &&
                             (item.code_length > cfg.min_code_length)) begin
                    pub_scan          = 1'b1;
                    n.mode            = MODE_SCANNING;
                    n.elapsed_ms      = '0;
                    n.scanner_enabled = 1'b0;
                end
            end
            MODE_SCANNING: begin
                if (timed_out(n.elapsed_ms, cfg.scan_timeout_ms)) begin
                    n.mode       = MODE_REFUSED;
                    n.elapsed_ms = '0;
                    n.motor      = MOTOR_REV;
                end
            end
            MODE_ACCEPTED: begin
                if (!n.first_seen && item.first_gate_low) begin
                    n.first_seen = 1'b1;
                end
                if (n.first_seen && !n.second_seen && item.second_gate_low) begin
                    n.second_seen = 1'b1;
                end
                if (n.first_seen && n.second_seen && !n.confirmed) begin
                    n.confirmed = 1'b1;
                    pub_confirm = 1'b1;
                end
                if (timed_out(n.elapsed_ms, cfg.accept_window_ms)) begin
                    n.motor = MOTOR_STOP;
                    if (n.confirmed) begin
                        n.mode = MODE_READY;
                    end else begin
                        n.mode       = MODE_REFUSED;
                        n.elapsed_ms = '0;
                        n.motor      = MOTOR_REV;
                    end
                    n.first_seen  = 1'b0;
                    n.second_seen = 1'b0;
                    n.confirmed   = 1'b0;
                end
            end
            MODE_REFUSED: begin
                if (timed_out(n.elapsed_ms, cfg.reject_time_ms)) begin
                    n.motor = MOTOR_STOP;
                    n.mode  = MODE_READY;
                end
            end
            default: begin
                n.motor = MOTOR_STOP;
            end
        endcase

        case (n.mode)
            MODE_READY:    led = LED_GREEN;
            MODE_DETECTED: led = LED_BLUE;
            MODE_SCANNING,
            MODE_ACCEPTED: led = n.blink_phase ? LED_BLUE : LED_OFF;
            MODE_REFUSED:  led = n.blink_phase ? LED_RED : LED_OFF;
            default:       led = LED_RED;
        endcase
    end

    assign state_upd              = n;
    assign result.mode_now        = n.mode;
    assign result.motor_direction = n.motor;
    assign result.motor_pwm       = (n.motor != MOTOR_STOP) ? cfg.drive_duty : '0;
    assign result.led_colour      = led;
    assign result.publish_scan    = pub_scan;
    assign result.publish_confirm = pub_confirm;

endmodule

// ----- rtl/deposit_kiosk_controller_unit.sv -----
// ----------------------------------------------------------------------------
// Deposit kiosk controller
// Steers a bottle-deposit kiosk through its modes, one request per millisecond.
// ----------------------------------------------------------------------------
// Path: an accepted request waits in the input register, then its result
// is registered in the output register through the tick logic once it is free.
// Throughput: one request per cycle while results are read; the tick logic
// is a single pass of compares and counter updates between the registers.
// Reset: synchronous, active low on aresetn; mode ready, timers cleared,
// scanner enabled, motor stopped, config registers back to their defaults.
module deposit_kiosk_controller_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Configuration write port.
    input  logic                                cfg_we,
    input  logic [dkc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [dkc_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    // Tick requests in.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // entry_edge[0], code_ready[1], code_length[9:2], verdict_valid[10],
    // verdict_ok[11], range_valid[12], range_cm[21:13], first_gate_low[22],
    // second_gate_low[23]
    input  logic [dkc_pkg::IN_DATA_BITS-1:0]    s_tdata,
    // Results out.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // mode_now[2:0], motor_direction[4:3], motor_pwm[12:5], led_colour[14:13],
    // publish_scan[15], publish_confirm[16], zeros above
    output logic [dkc_pkg::OUT_DATA_BITS-1:0]   m_tdata
);
    import dkc_pkg::*;

`include "deposit_kiosk_controller_unit_macros.svh"

    cfg_t      cfg;
    in_item_t  in_item_reg;
    in_item_t  in_item_next;
    logic      in_valid_reg;
    logic      in_valid_next;
    out_item_t out_item_reg;
    out_item_t out_item_next;
    logic      out_valid_reg;
    logic      out_valid_next;
    state_t    state_reg;
    state_t    state_next;
    state_t    state_upd;
    out_item_t step_result;
    logic      s_take;
    logic      advance;

    dkc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dkc_step u_step (
        .cfg       (cfg),
        .state_cur (state_reg),
        .item      (in_item_reg),
        .state_upd (state_upd),
        .result    (step_result)
    );

    // The held request moves on whenever the result register is free or is
    // being emptied in this cycle; the input register then refills at once.
    // While a result waits unread, the held request stays put and the input
    // side stalls with it.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_take   = s_tvalid && s_tready;

    always_comb begin
        in_item_next.entry_edge      = s_tdata[0];
        in_item_next.code_ready      = s_tdata[1];
        in_item_next.code_length     = s_tdata[9:2];
        in_item_next.verdict_valid   = s_tdata[10];
        in_item_next.verdict_ok      = s_tdata[11];
        in_item_next.range_valid     = s_tdata[12];
        in_item_next.range_cm        = s_tdata[21:13];
        in_item_next.first_gate_low  = s_tdata[22];
        in_item_next.second_gate_low = s_tdata[23];
    end

    always_comb begin
        if (s_take) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end

        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end

        // Kiosk state only moves when a tick is actually processed.
        state_next    = advance ? state_upd : state_reg;
        out_item_next = advance ? step_result : out_item_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= STATE_RST;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            state_reg     <= state_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_item_reg <= in_item_next;
        end
        out_item_reg <= out_item_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(OUT_DATA_BITS - OUT_USED_BITS)'(0), out_item_reg.publish_confirm,
                       out_item_reg.publish_scan, out_item_reg.led_colour,
                       out_item_reg.motor_pwm, out_item_reg.motor_direction,
                       out_item_reg.mode_now};

    // A published barcode always leaves the kiosk waiting for its verdict.
    `DKC_ASSERT_SAME(a_scan_mode, aclk, aresetn, out_valid_reg && out_item_reg.publish_scan, out_item_reg.mode_now == MODE_SCANNING)

    // Duty is only driven while the motor is running.
    `DKC_ASSERT_SAME(a_pwm_dir, aclk, aresetn, out_valid_reg && (out_item_reg.motor_pwm != '0), out_item_reg.motor_direction != MOTOR_STOP)

    // A full bin keeps the motor stopped.
    `DKC_ASSERT_SAME(a_full_stop, aclk, aresetn, state_reg.mode == MODE_FULL, state_reg.motor == MOTOR_STOP)

    // Kiosk state holds in any cycle in which no tick is processed.
    `DKC_ASSERT_NEXT(a_state_hold, aclk, aresetn, !advance, $stable(state_reg))

endmodule
